@@ hw/rtl/cmws_pkg.sv @@
// ----------------------------------------------------------------------------
// Circle map waveshaper package
// Shared widths, fixed-point constants, register indexes and status types.
// ----------------------------------------------------------------------------
package cmws_pkg;

  // Register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int DRIVE_W    = 15;
  localparam int MIX_W      = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_GAIN    = 2'd0,
    REG_MIX_FRACTION  = 2'd1,
    REG_BYPASS_ENABLE = 2'd2
  } cfg_reg_t;

  // Fixed-point constants
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [18:0] EXP_STEP_Q32   = 19'd522494;
  localparam logic [29:0] LN2_Q30        = 30'd744261118;
  localparam logic [MIX_W-1:0] MIX_FULL  = 13'd4096;

  // Compensation gain, unsigned Q1.24
  localparam int GAIN_W    = 25;
  localparam int GAIN_FRAC = 24;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 25'h1000000;

  // Sine table entries are unsigned Q1.15, the interpolated sine is signed Q1.15
  localparam int SINE_TAB_W = 16;
  localparam int SINE_W     = 17;

  // Pipeline split
  localparam int SINE_STAGES  = 4;
  localparam int SHAPE_STAGES = 8;
  localparam int NUM_STAGES   = SINE_STAGES + SHAPE_STAGES;

  // Gain unit status toward the datapath
  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] gain;
  } gain_stat_t;

  // Register values used by the shaping stages
  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [MIX_W-1:0]   mix;
    logic               bypass;
  } shape_cfg_t;

endpackage

@@ hw/rtl/cmws_gain.sv @@
// ----------------------------------------------------------------------------
// Compensation gain unit
// Sequencer that derives gain = 10^(-0.15*drive) in Q1.24 after each drive
// write: exponent multiply, then an exp() Taylor series whose per-term divide
// is a reciprocal multiply followed by one correction step.
// ----------------------------------------------------------------------------
module cmws_gain
  import cmws_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DRIVE_W-1:0] drive,
  output gain_stat_t         stat
);

  typedef enum logic [7:0] {
    G_IDLE  = 8'b00000001,
    G_EXP   = 8'b00000010,
    G_ZMUL  = 8'b00000100,
    G_TMUL  = 8'b00001000,
    G_QMUL  = 8'b00010000,
    G_QFIX  = 8'b00100000,
    G_ACC   = 8'b01000000,
    G_ROUND = 8'b10000000
  } gstate_t;

  typedef logic [31:0] recip_t [0:31];

  // Reciprocals floor((2^32-1)/d); the estimate they give is at most one low
  function automatic recip_t build_recip();
    recip_t r;
    r[0] = '0;
    for (int d = 1; d < 32; d++) begin
      r[d] = 32'(64'hFFFF_FFFF / 64'(d));
    end
    return r;
  endfunction

  localparam recip_t     RECIP     = build_recip();
  localparam logic [4:0] TERM_LAST = 5'd23;

  gstate_t            state;
  logic [DRIVE_W-1:0] drv;
  logic [1:0]         ip;
  logic [31:0]        fp;
  logic [29:0]        z;
  logic [30:0]        term;
  logic signed [31:0] sum;
  logic [4:0]         n;
  logic [29:0]        dvd;
  logic [29:0]        q0;
  logic [29:0]        quo;
  logic [GAIN_W-1:0]  gain;

  logic [33:0]        e_c;
  logic [59:0]        zp_c;
  logic [60:0]        tp_c;
  logic [61:0]        qp_c;
  logic [29:0]        rem_c;
  logic [29:0]        q_c;
  logic signed [31:0] sum_next;
  logic [30:0]        sum_cl;
  logic [3:0]         rnd_pos;
  logic [32:0]        rnd_sum;
  logic [GAIN_W-1:0]  gain_next;

  // Multipliers, quotient estimate and its correction
  always_comb begin
    e_c      = 34'(drv) * 34'(EXP_STEP_Q32);
    zp_c     = 60'(fp[31:2]) * 60'(LN2_Q30);
    tp_c     = 61'(term) * 61'(z);
    qp_c     = 62'(dvd) * 62'(RECIP[n]);
    rem_c    = dvd - 30'(35'(q0) * 35'(n));
    q_c      = (rem_c >= 30'(n)) ? q0 + 30'd1 : q0;
    sum_next = n[0] ? sum - $signed({2'b00, quo}) : sum + $signed({2'b00, quo});
  end

  // Scale by 2^-ip with round half up into Q1.24
  always_comb begin
    sum_cl    = sum[31] ? 31'd0 : sum[30:0];
    rnd_pos   = {2'b00, ip} + 4'd5;
    rnd_sum   = {2'b00, sum_cl} + (33'd1 << rnd_pos);
    gain_next = GAIN_W'(rnd_sum >> (rnd_pos + 4'd1));
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      gain  <= GAIN_ONE;
    end else begin
      unique case (state)
        G_IDLE: begin
          if (start) begin
            drv   <= drive;
            state <= G_EXP;
          end
        end
        G_EXP: begin
          ip    <= e_c[33:32];
          fp    <= e_c[31:0];
          state <= G_ZMUL;
        end
        G_ZMUL: begin
          z     <= zp_c[59:30];
          term  <= 31'h40000000;
          sum   <= 32'sh40000000;
          n     <= 5'd1;
          state <= G_TMUL;
        end
        G_TMUL: begin
          dvd   <= tp_c[59:30];
          state <= G_QMUL;
        end
        G_QMUL: begin
          q0    <= qp_c[61:32];
          state <= G_QFIX;
        end
        G_QFIX: begin
          quo   <= q_c;
          state <= G_ACC;
        end
        G_ACC: begin
          term <= {1'b0, quo};
          sum  <= sum_next;
          n    <= n + 5'd1;
          if (n == TERM_LAST || quo == '0) begin
            state <= G_ROUND;
          end else begin
            state <= G_TMUL;
          end
        end
        G_ROUND: begin
          gain  <= gain_next;
          state <= G_IDLE;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != G_IDLE);
  assign stat.gain = gain;

endmodule

@@ hw/rtl/cmws_sine.sv @@
// ----------------------------------------------------------------------------
// Sine front end
// Four pipeline stages: quadrant fold, table address, registered table read,
// linear interpolation and sign. Produces sin(2*pi*x) in signed Q1.15.
// ----------------------------------------------------------------------------
module cmws_sine
  import cmws_pkg::*;
#(
  parameter int SAMPLE_WIDTH       = 24,
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic                           clk,
  input  logic [SINE_STAGES-1:0]         en,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic signed [SAMPLE_WIDTH-1:0] x_out,
  output logic signed [SINE_W-1:0]       sine_out
);

  localparam int FRAC_BITS = SAMPLE_WIDTH - 1;
  localparam int QUAD_BITS = FRAC_BITS - 2;
  localparam int AW        = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int POS_W     = QUAD_BITS + 1 + AW;
  localparam int PROD_W    = QUAD_BITS + 18;
  localparam logic [AW-1:0]      LAST_IDX = AW'(SINE_TABLE_ENTRIES);
  localparam logic [QUAD_BITS:0] QUARTER  = {1'b1, {QUAD_BITS{1'b0}}};
  localparam logic [PROD_W-1:0]  HALF_LSB = PROD_W'(1) << (QUAD_BITS - 1);

  typedef logic [SINE_TAB_W-1:0] rom_t [0:SINE_TABLE_ENTRIES];

  // Quarter-wave table: Taylor series in Q2.30, rounded half up to Q1.15
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    longint      sum;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      th   = (64'(HALF_PI_Q30) * 64'(k)) / 64'(SINE_TABLE_ENTRIES);
      th2  = (th * th) >> 30;
      term = th;
      sum  = longint'(th);
      for (int i = 1; i < 24; i++) begin
        if (term != 64'd0) begin
          term = ((term * th2) >> 30) / 64'((2 * i) * (2 * i + 1));
          if ((i & 1) != 0) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
      rom[k] = SINE_TAB_W'((64'(sum) + 64'd16384) >> 15);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Stage 1 signals
  logic [1:0]                    quad_c;
  logic [QUAD_BITS:0]            rr_c;
  logic signed [SAMPLE_WIDTH-1:0] x1;
  logic [1:0]                    quad1;
  logic [QUAD_BITS:0]            rr1;
  // Stage 2 signals
  logic [POS_W-1:0]              pos_c;
  logic [AW-1:0]                 idx_c;
  logic [AW-1:0]                 idx1_c;
  logic signed [SAMPLE_WIDTH-1:0] x2;
  logic [1:0]                    quad2;
  logic [QUAD_BITS-1:0]          frac2;
  logic [SINE_TAB_W-1:0]         tab0;
  logic [SINE_TAB_W-1:0]         tab1;
  // Stage 3 signals
  logic signed [SINE_W-1:0]      diff_c;
  logic signed [PROD_W-1:0]      prod_c;
  logic signed [SAMPLE_WIDTH-1:0] x3;
  logic [1:0]                    quad3;
  logic [SINE_TAB_W-1:0]         tab0_3;
  logic signed [PROD_W-1:0]      prod3;
  // Stage 4 signals
  logic signed [PROD_W-1:0]      acc_c;
  logic signed [SINE_W-1:0]      mag_c;

  // Fold the phase into the first quadrant
  always_comb begin
    quad_c = sample_in[FRAC_BITS-1 -: 2];
    rr_c   = quad_c[0] ? QUARTER - {1'b0, sample_in[QUAD_BITS-1:0]}
                       : {1'b0, sample_in[QUAD_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1    <= sample_in;
      quad1 <= quad_c;
      rr1   <= rr_c;
    end
  end

  // Scale the folded phase to a table position; read both neighbors
  always_comb begin
    pos_c  = POS_W'(rr1) * POS_W'(SINE_TABLE_ENTRIES);
    idx_c  = pos_c[QUAD_BITS +: AW];
    idx1_c = (idx_c == LAST_IDX) ? idx_c : idx_c + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x2    <= x1;
      quad2 <= quad1;
      frac2 <= pos_c[QUAD_BITS-1:0];
      tab0  <= SINE_ROM[idx_c];
      tab1  <= SINE_ROM[idx1_c];
    end
  end

  // Weight the slope by the remaining phase bits
  always_comb begin
    diff_c = $signed({1'b0, tab1}) - $signed({1'b0, tab0});
    prod_c = diff_c * $signed({1'b0, frac2});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x3     <= x2;
      quad3  <= quad2;
      tab0_3 <= tab0;
      prod3  <= prod_c;
    end
  end

  // Round half up and apply the quadrant sign
  always_comb begin
    acc_c = $signed({2'b00, tab0_3, {QUAD_BITS{1'b0}}}) + prod3 + $signed(HALF_LSB);
    mag_c = $signed(acc_c[QUAD_BITS +: SINE_W]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x_out    <= x3;
      sine_out <= quad3[1] ? -mag_c : mag_c;
    end
  end

endmodule

@@ hw/rtl/cmws_shape.sv @@
// ----------------------------------------------------------------------------
// Shaping and mix back end
// Eight pipeline stages: circle-map term, rounding, sum, compensation gain,
// dry/wet products, blend with saturation and bypass into the output register.
// ----------------------------------------------------------------------------
module cmws_shape
  import cmws_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic [SHAPE_STAGES-1:0]        en,
  input  shape_cfg_t                     cfg,
  input  logic [GAIN_W-1:0]              gain,
  input  logic signed [SAMPLE_WIDTH-1:0] x_in,
  input  logic signed [SINE_W-1:0]       sine_in,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  localparam int FRAC_BITS = SAMPLE_WIDTH - 1;
  localparam int TERM_SH   = 59 - FRAC_BITS;
  localparam int DS_W      = DRIVE_W + 1 + SINE_W;
  localparam int T_W       = 62;
  localparam int YW        = SAMPLE_WIDTH + 3;
  localparam int YG_W      = YW + GAIN_W + 1;
  localparam int PX_W      = SAMPLE_WIDTH + MIX_W + 1;
  localparam int PW_W      = YW + MIX_W + 1;
  localparam int BL_W      = YW + MIX_W + 2;
  localparam logic [T_W-1:0]  T_HALF  = T_W'(1) << (TERM_SH - 1);
  localparam logic [YG_W-1:0] G_HALF  = YG_W'(1) << (GAIN_FRAC - 1);
  localparam logic [BL_W-1:0] B_HALF  = BL_W'(2048);
  localparam logic signed [BL_W-1:0] MAXV = BL_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [BL_W-1:0] MINV = ~MAXV;

  logic signed [SAMPLE_WIDTH-1:0] xs [SHAPE_STAGES-1];

  logic signed [DS_W-1:0]  ds;
  logic signed [T_W-1:0]   t;
  logic signed [T_W-1:0]   t_rnd_c;
  logic signed [YW-1:0]    term;
  logic signed [YW-1:0]    y;
  logic signed [YG_W-1:0]  yg;
  logic signed [YG_W-1:0]  yg_rnd_c;
  logic signed [YW-1:0]    wet;
  logic [MIX_W-1:0]        m_c;
  logic [MIX_W-1:0]        dry_c;
  logic signed [PX_W-1:0]  px;
  logic signed [PW_W-1:0]  pw;
  logic signed [BL_W-1:0]  bl_c;
  logic signed [BL_W-1:0]  res_c;
  logic signed [SAMPLE_WIDTH-1:0] sat_c;

  // Carry the dry sample alongside the datapath
  always_ff @(posedge clk) begin
    if (en[0]) xs[0] <= x_in;
    for (int i = 1; i < SHAPE_STAGES - 1; i++) begin
      if (en[i]) xs[i] <= xs[i-1];
    end
  end

  // Drive times sine, then times 1/(2*pi)
  always_ff @(posedge clk) begin
    if (en[0]) ds <= $signed({1'b0, cfg.drive}) * sine_in;
    if (en[1]) t  <= ds * $signed({1'b0, INV_TWO_PI_Q32});
  end

  // Round the circle-map term half away from zero to the sample format
  assign t_rnd_c = t + T_W'(T_HALF) - T_W'(t[T_W-1]);

  always_ff @(posedge clk) begin
    if (en[2]) term <= YW'(t_rnd_c >>> TERM_SH);
    if (en[3]) y    <= YW'(xs[2]) + term;
    if (en[4]) yg   <= y * $signed({1'b0, gain});
  end

  // Drop the gain fraction, rounding half away from zero
  assign yg_rnd_c = yg + G_HALF - YG_W'(yg[YG_W-1]);

  always_ff @(posedge clk) begin
    if (en[5]) wet <= YW'(yg_rnd_c >>> GAIN_FRAC);
  end

  // Dry and wet shares
  always_comb begin
    m_c   = (cfg.mix > MIX_FULL) ? MIX_FULL : cfg.mix;
    dry_c = MIX_FULL - m_c;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      px <= xs[5] * $signed({1'b0, dry_c});
      pw <= wet * $signed({1'b0, m_c});
    end
  end

  // Blend, round, saturate
  always_comb begin
    bl_c  = BL_W'(px) + BL_W'(pw);
    res_c = $signed(bl_c + B_HALF - BL_W'(bl_c[BL_W-1])) >>> 12;
    priority if (res_c > MAXV) begin
      sat_c = MAXV[SAMPLE_WIDTH-1:0];
    end else if (res_c < MINV) begin
      sat_c = MINV[SAMPLE_WIDTH-1:0];
    end else begin
      sat_c = res_c[SAMPLE_WIDTH-1:0];
    end
  end

  // Output register; bypass passes the dry sample
  always_ff @(posedge clk) begin
    if (en[7]) sample_out <= cfg.bypass ? xs[6] : sat_c;
  end

endmodule

@@ hw/rtl/circle_map_waveshaper_core.sv @@
// ----------------------------------------------------------------------------
// Circle map waveshaper core
// out = x*(1-mix) + mix * g * (x + drive/(2*pi) * sin(2*pi*x)), saturated,
// with g = 10^(-0.15*drive) and a bypass path.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                Payload
//  s_*       in   s_tvalid / s_tready      s_tdata: sample_in
//  m_*       out  m_tvalid / m_tready      m_tdata: sample_out
//  cfg_*     in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
//  One sample per cycle while m_tready is high and the gain unit is idle, through
//  12 stages (4 sine, 8 shaping). Reset is synchronous and leaves gain at 1.0.
//  Each stage holds its beat only while the stage after it is full and stalled,
//  so empty stages keep accepting while a result waits at the output.
//  A drive_gain write runs the gain unit through an exponent multiply, a ln2
//  multiply, up to 23 series terms (multiply, reciprocal multiply, correction,
//  accumulate) and a rounding step; s_tready and cfg_ready stay low meanwhile.
// ----------------------------------------------------------------------------
module circle_map_waveshaper_core
  import cmws_pkg::*;
#(
  parameter int SAMPLE_WIDTH       = 24,
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // [W-1:0] sample_in
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,   // [W-1:0] sample_out
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data
);

  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  shape_cfg_t                     cfg;
  gain_stat_t                     gstat;
  logic                           cfg_beat;
  logic                           s_beat;
  logic                           gain_start;
  logic [NUM_STAGES-1:0]          vld;
  logic [NUM_STAGES-1:0]          en;
  logic signed [SAMPLE_WIDTH-1:0] x_mid;
  logic signed [SINE_W-1:0]       sine_mid;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  // Configuration writes
  assign cfg_ready  = !gstat.busy;
  assign cfg_beat   = cfg_valid && cfg_ready;
  assign gain_start = cfg_beat && (cfg_index == REG_DRIVE_GAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive  <= '0;
      cfg.mix    <= '0;
      cfg.bypass <= 1'b0;
    end else if (cfg_beat) begin
      unique case (cfg_index)
        REG_DRIVE_GAIN:    cfg.drive  <= cfg_data[DRIVE_W-1:0];
        REG_MIX_FRACTION:  cfg.mix    <= cfg_data[MIX_W-1:0];
        REG_BYPASS_ENABLE: cfg.bypass <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cmws_gain u_gain (
    .clk   (clk),
    .rst   (rst),
    .start (gain_start),
    .drive (cfg_data[DRIVE_W-1:0]),
    .stat  (gstat)
  );

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0] && !gstat.busy;
  assign s_beat   = s_tvalid && s_tready;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_beat;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  cmws_sine #(
    .SAMPLE_WIDTH       (SAMPLE_WIDTH),
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_sine (
    .clk       (clk),
    .en        (en[SINE_STAGES-1:0]),
    .sample_in ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
    .x_out     (x_mid),
    .sine_out  (sine_mid)
  );

  cmws_shape #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_shape (
    .clk        (clk),
    .en         (en[NUM_STAGES-1:SINE_STAGES]),
    .cfg        (cfg),
    .gain       (gstat.gain),
    .x_in       (x_mid),
    .sine_in    (sine_mid),
    .sample_out (sample_out)
  );

  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tdata  = DW'($unsigned(sample_out));

  // No sample enters while the gain is being derived
  a_no_beat_while_busy: assert property (@(posedge clk) disable iff (rst)
    gstat.busy |-> !s_tready)
    else $error("input beat possible while gain unit busy");

  // A drive write starts the gain unit
  a_drive_starts_gain: assert property (@(posedge clk) disable iff (rst)
    gain_start |=> gstat.busy)
    else $error("drive write did not start gain unit");

  // An accepted sample occupies the first stage
  a_beat_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    s_beat |=> vld[0])
    else $error("accepted sample lost at pipeline entry");

endmodule
